### design/wfpd_pkg.sv
// shared types, register map and reset values for the wall-following pd drive
package wfpd_pkg;

	// register indexes on the configuration port (byte address is 4 * index)
	typedef enum logic [2:0] {
		REG_WALL_THRESHOLD  = 3'd0,
		REG_TARGET_DISTANCE = 3'd1,
		REG_FRONT_STOP      = 3'd2,
		REG_CELL_PULSES     = 3'd3,
		REG_BASE_LEFT       = 3'd4,
		REG_BASE_RIGHT      = 3'd5,
		REG_KP_GAIN         = 3'd6,
		REG_KD_GAIN         = 3'd7
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// reset values of the configuration registers
	localparam logic [9:0] RST_WALL_THRESHOLD  = 10'd300;
	localparam logic [9:0] RST_TARGET_DISTANCE = 10'd550;
	localparam logic [9:0] RST_FRONT_STOP      = 10'd400;
	localparam logic [9:0] RST_CELL_PULSES     = 10'd339;
	localparam logic [8:0] RST_BASE_LEFT       = 9'd375;
	localparam logic [8:0] RST_BASE_RIGHT      = 9'd300;
	localparam logic [7:0] RST_KP_GAIN         = 8'd102;
	localparam logic [7:0] RST_KD_GAIN         = 8'd82;

	// front wall ticks in one move that end it as blocked
	localparam logic [1:0] FRONT_HITS_MAX = 2'd3;

	typedef struct packed {
		logic [9:0] wall_threshold;
		logic [9:0] target_distance;
		logic [9:0] front_stop;
		logic [9:0] cell_pulses;
		logic [8:0] base_left;
		logic [8:0] base_right;
		logic [7:0] kp_gain;
		logic [7:0] kd_gain;
	} cfg_t;

	// one sensor tick
	typedef struct packed {
		logic       start_cell;
		logic [9:0] left_sample;
		logic [9:0] right_sample;
		logic [9:0] front_sample;
		logic [9:0] travelled;
	} tick_t;

	// one drive result
	typedef struct packed {
		logic signed [11:0] left_drive;
		logic signed [11:0] right_drive;
		logic               finished;
		logic               blocked;
		logic               cell_advanced;
	} drive_t;

	// controller state carried from tick to tick
	typedef struct packed {
		logic signed [11:0] previous_error;
		logic [1:0]         front_hits;
	} ctl_state_t;

endpackage

### design/wfpd_regs.sv
// configuration register file behind the apb-style port
module wfpd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wfpd_pkg::ADDR_W-1:0]   paddr,
	input  logic [wfpd_pkg::DATA_W-1:0]   pwdata,
	output logic [wfpd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output wfpd_pkg::cfg_t                cfg
);

	wfpd_pkg::cfg_t   cfg_q;
	wfpd_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = wfpd_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wall_threshold  <= wfpd_pkg::RST_WALL_THRESHOLD;
			cfg_q.target_distance <= wfpd_pkg::RST_TARGET_DISTANCE;
			cfg_q.front_stop      <= wfpd_pkg::RST_FRONT_STOP;
			cfg_q.cell_pulses     <= wfpd_pkg::RST_CELL_PULSES;
			cfg_q.base_left       <= wfpd_pkg::RST_BASE_LEFT;
			cfg_q.base_right      <= wfpd_pkg::RST_BASE_RIGHT;
			cfg_q.kp_gain         <= wfpd_pkg::RST_KP_GAIN;
			cfg_q.kd_gain         <= wfpd_pkg::RST_KD_GAIN;
		end else if (wr_en) begin
			unique case (idx)
				wfpd_pkg::REG_WALL_THRESHOLD:  cfg_q.wall_threshold  <= pwdata[9:0];
				wfpd_pkg::REG_TARGET_DISTANCE: cfg_q.target_distance <= pwdata[9:0];
				wfpd_pkg::REG_FRONT_STOP:      cfg_q.front_stop      <= pwdata[9:0];
				wfpd_pkg::REG_CELL_PULSES:     cfg_q.cell_pulses     <= pwdata[9:0];
				wfpd_pkg::REG_BASE_LEFT:       cfg_q.base_left       <= pwdata[8:0];
				wfpd_pkg::REG_BASE_RIGHT:      cfg_q.base_right      <= pwdata[8:0];
				wfpd_pkg::REG_KP_GAIN:         cfg_q.kp_gain         <= pwdata[7:0];
				wfpd_pkg::REG_KD_GAIN:         cfg_q.kd_gain         <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			wfpd_pkg::REG_WALL_THRESHOLD:  prdata = 32'(cfg_q.wall_threshold);
			wfpd_pkg::REG_TARGET_DISTANCE: prdata = 32'(cfg_q.target_distance);
			wfpd_pkg::REG_FRONT_STOP:      prdata = 32'(cfg_q.front_stop);
			wfpd_pkg::REG_CELL_PULSES:     prdata = 32'(cfg_q.cell_pulses);
			wfpd_pkg::REG_BASE_LEFT:       prdata = 32'(cfg_q.base_left);
			wfpd_pkg::REG_BASE_RIGHT:      prdata = 32'(cfg_q.base_right);
			wfpd_pkg::REG_KP_GAIN:         prdata = 32'(cfg_q.kp_gain);
			wfpd_pkg::REG_KD_GAIN:         prdata = 32'(cfg_q.kd_gain);
			default:                       prdata = '0;
		endcase
	end

endmodule

### design/wfpd_step.sv
// combinational tick logic: finish checks, error selection and pd correction
module wfpd_step (
	input  wfpd_pkg::cfg_t      cfg,
	input  wfpd_pkg::tick_t     tick,
	input  wfpd_pkg::ctl_state_t cur,
	output wfpd_pkg::drive_t    res,
	output wfpd_pkg::ctl_state_t nxt
);

	logic [1:0]         hits_base;
	logic [1:0]         hits_inc;
	logic               dist_done;
	logic               front_seen;
	logic               front_block;
	logic [11:0]        dist_x3p3;
	logic               third_reached;
	logic               lseen;
	logic               rseen;
	logic signed [11:0] lw_s;
	logic signed [11:0] rw_s;
	logic signed [11:0] tgt_s;
	logic signed [11:0] p;
	logic signed [12:0] d;
	logic signed [20:0] kp_w;
	logic signed [20:0] p_w;
	logic signed [20:0] prod_p;
	logic signed [21:0] kd_w;
	logic signed [21:0] d_w;
	logic signed [21:0] prod_d;
	logic signed [22:0] sum;
	logic signed [22:0] sum_adj;
	logic signed [11:0] pd;

	// front hit count for this tick
	assign hits_base   = tick.start_cell ? 2'd0 : cur.front_hits;
	assign hits_inc    = (hits_base == wfpd_pkg::FRONT_HITS_MAX) ? hits_base
	                                                             : hits_base + 2'd1;
	assign dist_done   = tick.travelled >= cfg.cell_pulses;
	assign front_seen  = tick.front_sample > cfg.front_stop;
	assign front_block = front_seen && (hits_inc == wfpd_pkg::FRONT_HITS_MAX);

	// travelled >= cell_pulses/3 is the same as 3*travelled + 3 > cell_pulses
	assign dist_x3p3     = {1'b0, tick.travelled, 1'b0} + 12'(tick.travelled) + 12'd3;
	assign third_reached = dist_x3p3 > 12'(cfg.cell_pulses);

	// error selection from the side walls
	assign lw_s  = 12'(tick.left_sample);
	assign rw_s  = 12'(tick.right_sample);
	assign tgt_s = 12'(cfg.target_distance);
	assign lseen = tick.left_sample >= cfg.wall_threshold;
	assign rseen = tick.right_sample >= cfg.wall_threshold;

	always_comb begin
		priority if (rseen && lseen) begin
			p = rw_s - lw_s;
			d = 13'(p) - 13'(cur.previous_error);
		end else if (rseen) begin
			p = (rw_s - tgt_s) <<< 1;
			d = 13'(p) - 13'(cur.previous_error);
		end else if (lseen) begin
			p = (tgt_s - lw_s) <<< 1;
			d = 13'(p) - 13'(cur.previous_error);
		end else begin
			p = '0;
			d = '0;
		end
	end

	// pd sum with q0.8 gains, truncated toward zero
	assign kp_w    = 21'(cfg.kp_gain);
	assign p_w     = 21'(p);
	assign prod_p  = kp_w * p_w;
	assign kd_w    = 22'(cfg.kd_gain);
	assign d_w     = 22'(d);
	assign prod_d  = kd_w * d_w;
	assign sum     = 23'(prod_p) + 23'(prod_d);
	assign sum_adj = sum[22] ? sum + 23'sd255 : sum;
	assign pd      = sum_adj[19:8];

	// result and next state
	always_comb begin
		res.left_drive     = 12'(cfg.base_left) - pd;
		res.right_drive    = 12'(cfg.base_right) + pd;
		res.finished       = 1'b0;
		res.blocked        = 1'b0;
		res.cell_advanced  = 1'b0;
		nxt.previous_error = p;
		nxt.front_hits     = front_seen ? hits_inc : hits_base;
		priority if (dist_done) begin
			res.left_drive     = '0;
			res.right_drive    = '0;
			res.finished       = 1'b1;
			res.cell_advanced  = 1'b1;
			nxt.previous_error = cur.previous_error;
			nxt.front_hits     = hits_base;
		end else if (front_block) begin
			res.left_drive     = '0;
			res.right_drive    = '0;
			res.finished       = 1'b1;
			res.blocked        = 1'b1;
			res.cell_advanced  = third_reached;
			nxt.previous_error = cur.previous_error;
		end else begin
		end
	end

endmodule

### design/wall_following_pd_drive.sv
// top level of the wall-following pd drive for one maze-cell move
//
// Input channel: one beat per control tick (start_cell, the three ir samples
// and travelled), accepted when in_valid is high and in_stall is low.
// Output channel: one beat per tick (left_drive, right_drive, finished,
// blocked, cell_advanced), taken when out_valid is high and out_stall low.
// Configuration: eight registers on the apb-style port at byte address 4*i;
// the user writes them only while no tick is in flight; the block won't check.
// Path: each input beat goes to the input register, then to the result
// register, fed by the single-pass pd logic.
// Throughput: one tick per cycle while out_stall is low; the pd state and
// front-hit count update as each tick moves into the result register.
// Reset: configuration returns to its defaults, previous error and front
// hit count clear, both pipeline stages empty.
// Stall: a waiting result holds in the result register; one more tick is
// taken into the input register, after that in_stall follows out_stall.
module wall_following_pd_drive (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wfpd_pkg::ADDR_W-1:0] paddr,
	input  logic [wfpd_pkg::DATA_W-1:0] pwdata,
	output logic [wfpd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        start_cell,
	input  logic [9:0]                  left_sample,
	input  logic [9:0]                  right_sample,
	input  logic [9:0]                  front_sample,
	input  logic [9:0]                  travelled,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [11:0]          left_drive,
	output logic signed [11:0]          right_drive,
	output logic                        finished,
	output logic                        blocked,
	output logic                        cell_advanced
);

	wfpd_pkg::cfg_t       cfg;
	wfpd_pkg::tick_t      tick_s1;
	logic                 valid_s1;
	wfpd_pkg::drive_t     res;
	wfpd_pkg::drive_t     res_s2;
	logic                 valid_s2;
	wfpd_pkg::ctl_state_t state_q;
	wfpd_pkg::ctl_state_t state_nxt;
	logic                 s2_free;
	logic                 adv_s1;
	logic                 in_take;

	wfpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wfpd_step u_step (
		.cfg  (cfg),
		.tick (tick_s1),
		.cur  (state_q),
		.res  (res),
		.nxt  (state_nxt)
	);

	// handshake between the stages
	assign s2_free  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_s1.start_cell   <= start_cell;
			tick_s1.left_sample  <= left_sample;
			tick_s1.right_sample <= right_sample;
			tick_s1.front_sample <= front_sample;
			tick_s1.travelled    <= travelled;
		end
	end

	// result register and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign left_drive    = res_s2.left_drive;
	assign right_drive   = res_s2.right_drive;
	assign finished      = res_s2.finished;
	assign blocked       = res_s2.blocked;
	assign cell_advanced = res_s2.cell_advanced;

	// a finished move always reports zero drive
	a_finish_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && finished) |-> (left_drive == 12'sd0 && right_drive == 12'sd0))
		else $error("finished beat with nonzero drive");

	// blocked or cell_advanced only on a finished beat
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !finished) |-> (!blocked && !cell_advanced))
		else $error("move flags set on a running beat");

	// input is only held off while the result register is full and stalled
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// a blocked finish leaves the front count saturated
	a_block_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res.blocked) |=> (state_q.front_hits == wfpd_pkg::FRONT_HITS_MAX))
		else $error("front count not saturated after a blocked finish");

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the wall-following pd drive: directed rows, then random moves
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 500000;
	localparam int N_PHASES    = 8;
	localparam int PRINT_CAP   = 40;

	// clock, reset and block ports
	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          psel         = 1'b0;
	logic                          penable      = 1'b0;
	logic                          pwrite       = 1'b0;
	logic [wfpd_pkg::ADDR_W-1:0]   paddr        = '0;
	logic [wfpd_pkg::DATA_W-1:0]   pwdata       = '0;
	logic [wfpd_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic                          start_cell   = 1'b0;
	logic [9:0]                    left_sample  = '0;
	logic [9:0]                    right_sample = '0;
	logic [9:0]                    front_sample = '0;
	logic [9:0]                    travelled    = '0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic signed [11:0]            left_drive;
	logic signed [11:0]            right_drive;
	logic                          finished;
	logic                          blocked;
	logic                          cell_advanced;

	wall_following_pd_drive DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_cell(start_cell), .left_sample(left_sample), .right_sample(right_sample),
		.front_sample(front_sample), .travelled(travelled),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_drive(left_drive), .right_drive(right_drive), .finished(finished),
		.blocked(blocked), .cell_advanced(cell_advanced)
	);

	// directed row: a tick and, where obvious, its drive result
	typedef struct {
		wfpd_pkg::tick_t  tk;
		bit               typed;
		wfpd_pkg::drive_t want;
	} dir_row_t;

	dir_row_t         directed_rows[$];
	wfpd_pkg::drive_t pending_drives[$];
	wfpd_pkg::drive_t head;

	// predictor copy of configuration and controller state
	wfpd_pkg::cfg_t cfg = '{wall_threshold: wfpd_pkg::RST_WALL_THRESHOLD,
		target_distance: wfpd_pkg::RST_TARGET_DISTANCE,
		front_stop: wfpd_pkg::RST_FRONT_STOP, cell_pulses: wfpd_pkg::RST_CELL_PULSES,
		base_left: wfpd_pkg::RST_BASE_LEFT, base_right: wfpd_pkg::RST_BASE_RIGHT,
		kp_gain: wfpd_pkg::RST_KP_GAIN, kd_gain: wfpd_pkg::RST_KD_GAIN};
	int prev_err   = 0;
	int front_seen = 0;

	int errors     = 0;
	int cycles     = 0;
	int n_ticks    = 0;
	int n_results  = 0;
	int n_finished = 0;
	int n_blocked  = 0;
	int n_advanced = 0;
	int gap_pct    = 0;
	int stall_pct  = 0;
	int stall_left = 0;

	always #5 clk = ~clk;

	task automatic report(input string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// expected drive for one tick; updates the predictor state
	function automatic wfpd_pkg::drive_t drive_for_tick(input wfpd_pkg::tick_t t);
		wfpd_pkg::drive_t r;
		int l, rt, tgt, p, d, pd, kp, kd, bl, br;
		bit lseen, rseen;
		r = '0;
		l = t.left_sample;
		rt = t.right_sample;
		tgt = cfg.target_distance;
		kp = cfg.kp_gain;
		kd = cfg.kd_gain;
		bl = cfg.base_left;
		br = cfg.base_right;
		if (t.start_cell)
			front_seen = 0;
		// distance reached wins over the front wall
		if (t.travelled >= cfg.cell_pulses) begin
			r.finished = 1'b1;
			r.cell_advanced = 1'b1;
			return r;
		end
		// front wall, counted and saturating at three
		if (t.front_sample > cfg.front_stop) begin
			if (front_seen < 3)
				front_seen++;
			if (front_seen > 2) begin
				r.finished = 1'b1;
				r.blocked = 1'b1;
				r.cell_advanced = (t.travelled >= cfg.cell_pulses / 3);
				return r;
			end
		end
		// error picked by the side walls in view
		lseen = (t.left_sample >= cfg.wall_threshold);
		rseen = (t.right_sample >= cfg.wall_threshold);
		if (lseen && rseen) begin
			p = rt - l;
			d = p - prev_err;
		end else if (rseen) begin
			p = 2 * (rt - tgt);
			d = p - prev_err;
		end else if (lseen) begin
			p = 2 * (tgt - l);
			d = p - prev_err;
		end else begin
			p = 0;
			d = 0;
		end
		pd = (kp * p + kd * d) / 256;
		prev_err = p;
		r.left_drive = 12'(bl - pd);
		r.right_drive = 12'(br + pd);
		return r;
	endfunction

	// receiver: random stall bursts on out_stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result beats against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drives.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				head = pending_drives.pop_front();
				n_results++;
				if (left_drive !== head.left_drive)
					report($sformatf("left_drive %0d, expected %0d", left_drive, head.left_drive));
				if (right_drive !== head.right_drive)
					report($sformatf("right_drive %0d, expected %0d", right_drive,
						head.right_drive));
				if (finished !== head.finished)
					report($sformatf("finished %0b, expected %0b", finished, head.finished));
				if (blocked !== head.blocked)
					report($sformatf("blocked %0b, expected %0b", blocked, head.blocked));
				if (cell_advanced !== head.cell_advanced)
					report($sformatf("cell_advanced %0b, expected %0b", cell_advanced,
						head.cell_advanced));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one input beat; expectation from the predictor unless typed in
	task automatic send_tick(input wfpd_pkg::tick_t t, input bit typed,
		input wfpd_pkg::drive_t want);
		wfpd_pkg::drive_t got;
		in_valid <= 1'b1;
		start_cell <= t.start_cell;
		left_sample <= t.left_sample;
		right_sample <= t.right_sample;
		front_sample <= t.front_sample;
		travelled <= t.travelled;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = drive_for_tick(t);
		pending_drives.push_back(typed ? want : got);
		n_ticks++;
		if (got.finished) begin
			n_finished++;
			if (got.blocked)
				n_blocked++;
			if (got.cell_advanced)
				n_advanced++;
		end
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// hold the sender until every expected beat has come
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// one apb transfer, after which the bus goes idle
	task automatic apb_access(input wfpd_pkg::reg_idx_t idx, input bit wr,
		input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] reg_value(input wfpd_pkg::cfg_t c,
		input wfpd_pkg::reg_idx_t idx);
		case (idx)
			wfpd_pkg::REG_WALL_THRESHOLD:  return 32'(c.wall_threshold);
			wfpd_pkg::REG_TARGET_DISTANCE: return 32'(c.target_distance);
			wfpd_pkg::REG_FRONT_STOP:      return 32'(c.front_stop);
			wfpd_pkg::REG_CELL_PULSES:     return 32'(c.cell_pulses);
			wfpd_pkg::REG_BASE_LEFT:       return 32'(c.base_left);
			wfpd_pkg::REG_BASE_RIGHT:      return 32'(c.base_right);
			wfpd_pkg::REG_KP_GAIN:         return 32'(c.kp_gain);
			default:                       return 32'(c.kd_gain);
		endcase
	endfunction

	// write all registers, then read them back
	task automatic load_config(input wfpd_pkg::cfg_t c);
		logic [31:0] rd;
		wfpd_pkg::reg_idx_t idx;
		for (int i = 0; i < 8; i++) begin
			idx = wfpd_pkg::reg_idx_t'(i);
			apb_access(idx, 1'b1, reg_value(c, idx), rd);
		end
		cfg = c;
		for (int i = 0; i < 8; i++) begin
			idx = wfpd_pkg::reg_idx_t'(i);
			apb_access(idx, 1'b0, '0, rd);
			if (rd !== reg_value(c, idx))
				report($sformatf("register %s reads %0d, expected %0d", idx.name(), rd,
					reg_value(c, idx)));
		end
	endtask

	function automatic logic [9:0] clamp10(input int v);
		if (v < 0)
			return 10'd0;
		if (v > 1023)
			return 10'd1023;
		return 10'(v);
	endfunction

	// side samples clustered around the threshold and the target
	function automatic logic [9:0] pick_side();
		int thr, tgt;
		thr = cfg.wall_threshold;
		tgt = cfg.target_distance;
		case ($urandom_range(0, 7))
			0:       return 10'd0;
			1:       return 10'd1023;
			2:       return clamp10(thr);
			3:       return clamp10(thr - 1);
			4:       return clamp10(tgt + $urandom_range(0, 80) - 40);
			5, 6:    return clamp10($urandom_range(thr, 1023));
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [9:0] front_clear();
		int fs;
		fs = cfg.front_stop;
		return ($urandom_range(0, 3) == 0) ? 10'(fs) : 10'($urandom_range(0, fs));
	endfunction

	function automatic logic [9:0] front_wall();
		int fs;
		fs = cfg.front_stop;
		if (fs >= 1023)
			return 10'd1023;
		return ($urandom_range(0, 3) == 0) ? 10'(fs + 1) : 10'($urandom_range(fs + 1, 1023));
	endfunction

	// one cell move: start tick, rising distance, sometimes a front wall stretch
	task automatic run_move();
		wfpd_pkg::tick_t t;
		int trav, step, n, wall_from, wall_len;
		bit walled;
		step = cfg.cell_pulses / 6 + 1;
		trav = 0;
		walled = ($urandom_range(0, 3) == 0);
		wall_from = $urandom_range(0, 5);
		wall_len = $urandom_range(1, 5);
		for (n = 0; n < 64; n++) begin
			t.start_cell = (n == 0);
			t.left_sample = pick_side();
			t.right_sample = pick_side();
			t.front_sample = (walled && n >= wall_from && n < wall_from + wall_len) ?
				front_wall() : front_clear();
			t.travelled = clamp10(trav);
			send_tick(t, 1'b0, '0);
			if (trav >= cfg.cell_pulses)
				break;
			if (walled && n + 1 >= wall_from + wall_len && $urandom_range(0, 1) == 0)
				break;
			trav += $urandom_range(0, step);
		end
	endtask

	task automatic send_noise();
		wfpd_pkg::tick_t t;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		t = raw[$bits(wfpd_pkg::tick_t)-1:0];
		send_tick(t, 1'b0, '0);
	endtask

	task automatic add_row(input bit s, input int l, input int r, input int f, input int trav,
		input bit typed, input int ld, input int rd, input bit fin, input bit blk, input bit ca);
		dir_row_t row;
		row.tk = '{start_cell: s, left_sample: 10'(l), right_sample: 10'(r),
			front_sample: 10'(f), travelled: 10'(trav)};
		row.typed = typed;
		row.want = '{left_drive: 12'(ld), right_drive: 12'(rd), finished: fin,
			blocked: blk, cell_advanced: ca};
		directed_rows.push_back(row);
	endtask

	// settings for each random phase, extremes first
	function automatic wfpd_pkg::cfg_t phase_cfg(input int k);
		wfpd_pkg::cfg_t c;
		case (k)
			0: c = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 9'd511, 9'd511, 8'd255, 8'd255};
			1: c = '{10'd0, 10'd0, 10'd0, 10'd0, 9'd0, 9'd0, 8'd0, 8'd0};
			2: c = '{10'd0, 10'd0, 10'd0, 10'd1, 9'd0, 9'd0, 8'd0, 8'd0};
			3: c = '{10'd200, 10'd0, 10'd700, 10'd1023, 9'd511, 9'd0, 8'd255, 8'd255};
			N_PHASES - 1: c = '{wfpd_pkg::RST_WALL_THRESHOLD, wfpd_pkg::RST_TARGET_DISTANCE,
				wfpd_pkg::RST_FRONT_STOP, wfpd_pkg::RST_CELL_PULSES, wfpd_pkg::RST_BASE_LEFT,
				wfpd_pkg::RST_BASE_RIGHT, wfpd_pkg::RST_KP_GAIN, wfpd_pkg::RST_KD_GAIN};
			default: begin
				c.wall_threshold = 10'($urandom_range(100, 700));
				c.target_distance = 10'($urandom_range(0, 1023));
				c.front_stop = 10'($urandom_range(200, 1023));
				c.cell_pulses = 10'($urandom_range(1, 1023));
				c.base_left = 9'($urandom_range(0, 511));
				c.base_right = 9'($urandom_range(0, 511));
				c.kp_gain = 8'($urandom_range(0, 255));
				c.kd_gain = 8'($urandom_range(0, 255));
			end
		endcase
		return c;
	endfunction

	initial begin : stimulus
		int goal;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings
		add_row(1, 0, 0, 0, 0,             1, 375, 300, 0, 0, 0);
		add_row(0, 1023, 1023, 0, 0,       0, 0, 0, 0, 0, 0);
		add_row(0, 1023, 0, 0, 0,          0, 0, 0, 0, 0, 0);
		add_row(0, 0, 1023, 0, 0,          0, 0, 0, 0, 0, 0);
		add_row(0, 300, 299, 0, 0,         0, 0, 0, 0, 0, 0);
		add_row(0, 299, 300, 0, 0,         0, 0, 0, 0, 0, 0);
		add_row(0, 512, 700, 400, 338,     0, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 339,           1, 0, 0, 1, 0, 1);
		add_row(0, 1023, 1023, 1023, 1023, 1, 0, 0, 1, 0, 1);
		add_row(1, 0, 0, 1023, 0,          1, 375, 300, 0, 0, 0);
		add_row(0, 0, 0, 401, 0,           1, 375, 300, 0, 0, 0);
		add_row(0, 0, 0, 401, 112,         1, 0, 0, 1, 1, 0);
		add_row(0, 0, 0, 1023, 113,        1, 0, 0, 1, 1, 1);
		add_row(0, 1023, 1023, 1023, 338,  1, 0, 0, 1, 1, 1);
		add_row(0, 0, 0, 1023, 339,        1, 0, 0, 1, 0, 1);
		add_row(1, 0, 0, 1023, 0,          1, 375, 300, 0, 0, 0);
		add_row(0, 700, 0, 0, 0,           0, 0, 0, 0, 0, 0);
		add_row(1, 0, 0, 0, 0,             1, 375, 300, 0, 0, 0);
		gap_pct = 20;
		stall_pct = 10;
		foreach (directed_rows[i])
			send_tick(directed_rows[i].tk, directed_rows[i].typed, directed_rows[i].want);
		drain();

		// random phases, each under its own settings
		for (int k = 0; k < N_PHASES; k++) begin
			load_config(phase_cfg(k));
			if (k == N_PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = $urandom_range(0, 3) * 8;
				stall_pct = $urandom_range(0, 3) * 8;
			end
			goal = n_ticks + ((k == 1) ? 40 : 210);
			while (n_ticks < goal) begin
				if ($urandom_range(0, 4) == 0)
					send_noise();
				else
					run_move();
				if ($urandom_range(0, 59) == 0)
					drain();
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (pending_drives.size() != 0)
			report($sformatf("%0d expected beats never came", pending_drives.size()));
		$display("covered %0d ticks under %0d settings: %0d finished, %0d blocked, %0d as cells",
			n_ticks, N_PHASES + 1, n_finished, n_blocked, n_advanced);
		$display("checked %0d result beats, %0d mismatches", n_results, errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
design/wfpd_pkg.sv
design/wfpd_regs.sv
design/wfpd_step.sv
design/wall_following_pd_drive.sv
tb/sv/testbench.sv
